/* hdl/kcri_pkg.sv */
package kcri_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 16;
   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int CNT_BITS    = $clog2(ENTRIES + 1);
   localparam int SLOT_BITS   = 4;
   localparam int CHAN_BITS   = 8;
   localparam int NUM_CHANS   = 3;
   localparam int COLOR_BITS  = CHAN_BITS * NUM_CHANS;
   localparam int NUM_BITS    = KEY_BITS + CHAN_BITS + 1;
   localparam int STEP_BITS   = $clog2(CHAN_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_QUERY = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CMD_QUERY,
      CMD_WRITE,
      CMD_CLEAR
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_PREP,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [15:0] anchor_key;
      logic [23:0] anchor_color;
      logic [15:0] query_value;
   } req_type;

   typedef struct packed {
      logic [23:0] color;
      logic        table_empty;
   } rsp_type;

   // For a query the key field carries the query value.
   typedef struct packed {
      cmd_kind_type            kind;
      logic [IDX_BITS-1:0]     idx;
      logic [KEY_BITS-1:0]     key;
      logic [COLOR_BITS-1:0]   color;
   } cmd_type;

endpackage

/* hdl/keyed_color_ramp_interpolator_core.sv */
// Channel   Ports                            Direction  Moves
// request   req_valid req_ready req_data     in         query, write or clear
// response  rsp_valid rsp_ready rsp_data     out        one color per query
//
// Writes and clears are done by the execution unit directly from idle. A query
// scans the anchor table one slot per cycle and then either blends two anchors
// through the eight-step quotient loop or matches or clamps. Reset is synchronous
// and drops every anchor. A stalled response holds the execution unit, while the
// two-entry command queue keeps taking requests until it fills.
module keyed_color_ramp_interpolator_core (
   input  logic              clock,
   input  logic              reset,
   input  kcri_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_ready,
   output kcri_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready
);
   import kcri_pkg::*;

   cmd_type front_cmd;
   logic    front_valid, front_ready;
   cmd_type back_cmd;
   logic    back_valid, back_ready;

   kcri_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd_data  (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   kcri_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (back_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   kcri_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

/* hdl/kcri_front.sv */
module kcri_front (
   input  logic              clock,
   input  logic              reset,
   input  kcri_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_ready,
   output kcri_pkg::cmd_type cmd_data,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import kcri_pkg::*;

   cmd_type cmd_ff, cmd_in;
   logic    cmd_valid_ff, cmd_valid_in;
   logic    keep;
   cmd_type cls;
   logic [IDX_BITS+SLOT_BITS-1:0] slot_wide;

   assign slot_wide = (IDX_BITS + SLOT_BITS)'(req_data.slot);

   // Classify the incoming transaction; unused codes and writes to slots
   // beyond the table are dropped here.
   always_comb begin
      keep      = 1'b0;
      cls.kind  = CMD_QUERY;
      cls.idx   = slot_wide[IDX_BITS-1:0];
      cls.key   = KEY_BITS'(req_data.anchor_key);
      cls.color = req_data.anchor_color;
      case (req_data.action)
         ACT_QUERY: begin
            keep     = 1'b1;
            cls.kind = CMD_QUERY;
            cls.key  = KEY_BITS'(req_data.query_value);
         end
         ACT_WRITE: begin
            keep     = (slot_wide < (IDX_BITS + SLOT_BITS)'(ENTRIES));
            cls.kind = CMD_WRITE;
         end
         ACT_CLEAR: begin
            keep     = 1'b1;
            cls.kind = CMD_CLEAR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !cmd_valid_ff || cmd_ready;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_in       = cmd_ff;
      if (cmd_valid_ff && cmd_ready) begin
         cmd_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         cmd_valid_in = keep;
         cmd_in       = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_data  = cmd_ff;
   assign cmd_valid = cmd_valid_ff;

endmodule

/* hdl/kcri_queue.sv */
module kcri_queue (
   input  logic              clock,
   input  logic              reset,
   input  kcri_pkg::cmd_type in_data,
   input  logic              in_valid,
   output logic              in_ready,
   output kcri_pkg::cmd_type out_data,
   output logic              out_valid,
   input  logic              out_ready
);
   import kcri_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* hdl/kcri_back.sv */
module kcri_back (
   input  logic              clock,
   input  logic              reset,
   input  kcri_pkg::cmd_type cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   output kcri_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready
);
   import kcri_pkg::*;

   back_state_type state_ff, state_in;

   logic [ENTRIES-1:0]     valid_ff;
   logic [KEY_BITS-1:0]    key_mem_ff   [ENTRIES];
   logic [COLOR_BITS-1:0]  color_mem_ff [ENTRIES];

   logic [CNT_BITS-1:0]    cnt_ff;
   logic [IDX_BITS-1:0]    rd_addr;
   logic                   scan_issue;
   logic                   rd_pend_ff;
   logic                   rd_valid_ff;
   logic [KEY_BITS-1:0]    rd_key_ff;
   logic [COLOR_BITS-1:0]  rd_color_ff;

   logic [KEY_BITS-1:0]    qv_ff;
   logic                   any_ff, eq_hit_ff, lo_hit_ff, hi_hit_ff;
   logic [COLOR_BITS-1:0]  eq_color_ff, lo_color_ff, hi_color_ff;
   logic [KEY_BITS-1:0]    lo_key_ff, hi_key_ff;

   logic [KEY_BITS-1:0]    span_ff, dl_ff, du_ff;
   logic [NUM_BITS-1:0]    num_in  [NUM_CHANS];
   logic [NUM_BITS-1:0]    rem_ff  [NUM_CHANS];
   logic [NUM_BITS-1:0]    rem_in  [NUM_CHANS];
   logic [CHAN_BITS-1:0]   quo_ff  [NUM_CHANS];
   logic [CHAN_BITS-1:0]   quo_in  [NUM_CHANS];
   logic [COLOR_BITS-1:0]  quo_color;
   logic [NUM_BITS-1:0]    dvs_ff;
   logic [STEP_BITS-1:0]   step_ff;

   rsp_type                res_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   start_query, do_write, do_clear, load_rsp, interp;

   assign rd_addr    = cnt_ff[IDX_BITS-1:0];
   assign scan_issue = (state_ff == BK_SCAN) && (cnt_ff != CNT_BITS'(ENTRIES));
   assign interp     = any_ff && !eq_hit_ff && lo_hit_ff && hi_hit_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_ready    = 1'b0;
      start_query  = 1'b0;
      do_write     = 1'b0;
      do_clear     = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd_data.kind)
                  CMD_QUERY: begin
                     start_query = 1'b1;
                     state_in    = BK_SCAN;
                  end
                  CMD_WRITE: do_write = 1'b1;
                  CMD_CLEAR: do_clear = 1'b1;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_SCAN: begin
            // The last slot's read data is evaluated in the cycle that leaves.
            if (cnt_ff == CNT_BITS'(ENTRIES)) begin
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            state_in = interp ? BK_MUL : BK_DONE;
         end
         BK_MUL: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (step_ff == STEP_BITS'(CHAN_BITS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= scan_issue;
         if (do_clear) begin
            valid_ff <= '0;
         end else if (do_write) begin
            valid_ff[cmd_data.idx] <= 1'b1;
         end
      end
   end

   // Anchor memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         key_mem_ff[cmd_data.idx]   <= cmd_data.key;
         color_mem_ff[cmd_data.idx] <= cmd_data.color;
      end
      rd_key_ff   <= key_mem_ff[rd_addr];
      rd_color_ff <= color_mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Scan: slots come in ascending order, so strict compares keep the
   // lowest slot among equal keys.
   always_ff @(posedge clock) begin
      if (start_query) begin
         cnt_ff    <= '0;
         qv_ff     <= cmd_data.key;
         any_ff    <= 1'b0;
         eq_hit_ff <= 1'b0;
         lo_hit_ff <= 1'b0;
         hi_hit_ff <= 1'b0;
      end else begin
         if (scan_issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rd_pend_ff && rd_valid_ff) begin
            any_ff <= 1'b1;
            if (rd_key_ff == qv_ff) begin
               if (!eq_hit_ff) begin
                  eq_hit_ff   <= 1'b1;
                  eq_color_ff <= rd_color_ff;
               end
            end else if (rd_key_ff < qv_ff) begin
               if (!lo_hit_ff || rd_key_ff > lo_key_ff) begin
                  lo_hit_ff   <= 1'b1;
                  lo_key_ff   <= rd_key_ff;
                  lo_color_ff <= rd_color_ff;
               end
            end else begin
               if (!hi_hit_ff || rd_key_ff < hi_key_ff) begin
                  hi_hit_ff   <= 1'b1;
                  hi_key_ff   <= rd_key_ff;
                  hi_color_ff <= rd_color_ff;
               end
            end
         end
      end
   end

   // Per-channel numerators and one restoring-division step per cycle.
   always_comb begin
      logic [KEY_BITS+CHAN_BITS-1:0] pl;
      logic [KEY_BITS+CHAN_BITS-1:0] pu;
      for (int c = 0; c < NUM_CHANS; c++) begin
         pl = lo_color_ff[c*CHAN_BITS +: CHAN_BITS] * dl_ff;
         pu = hi_color_ff[c*CHAN_BITS +: CHAN_BITS] * du_ff;
         num_in[c] = NUM_BITS'(pl) + NUM_BITS'(pu);
         if (rem_ff[c] >= dvs_ff) begin
            rem_in[c] = rem_ff[c] - dvs_ff;
            quo_in[c] = {quo_ff[c][CHAN_BITS-2:0], 1'b1};
         end else begin
            rem_in[c] = rem_ff[c];
            quo_in[c] = {quo_ff[c][CHAN_BITS-2:0], 1'b0};
         end
         quo_color[c*CHAN_BITS +: CHAN_BITS] = quo_in[c];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_PREP: begin
            span_ff <= hi_key_ff - lo_key_ff;
            dl_ff   <= hi_key_ff - qv_ff;
            du_ff   <= qv_ff - lo_key_ff;
            res_ff.table_empty <= !any_ff;
            if (!any_ff) begin
               res_ff.color <= '0;
            end else if (eq_hit_ff) begin
               res_ff.color <= eq_color_ff;
            end else if (!lo_hit_ff) begin
               res_ff.color <= hi_color_ff;
            end else begin
               res_ff.color <= lo_color_ff;
            end
         end
         BK_MUL: begin
            for (int c = 0; c < NUM_CHANS; c++) begin
               rem_ff[c] <= num_in[c];
               quo_ff[c] <= '0;
            end
            dvs_ff  <= NUM_BITS'(span_ff) << (CHAN_BITS - 1);
            step_ff <= '0;
         end
         BK_DIV: begin
            for (int c = 0; c < NUM_CHANS; c++) begin
               rem_ff[c] <= rem_in[c];
               quo_ff[c] <= quo_in[c];
            end
            dvs_ff  <= dvs_ff >> 1;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CHAN_BITS - 1)) begin
               res_ff.color <= quo_color;
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/kcri_checker.sv */
module kcri_checker (
   input logic              clock,
   input logic              reset,
   input kcri_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_ready
);
   import kcri_pkg::*;

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // An empty table always reports black.
   a_empty_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_empty |-> rsp_data.color == '0)
      else $error("empty-table response carries a color");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind keyed_color_ramp_interpolator_core kcri_checker u_checker (.*);
